### hw/rtl/hvd_pkg.sv
// ----------------------------------------------------------------------------
// hvd_pkg: shared types and constants for the haversine distance pipeline
// Fixed-point constants, CORDIC arctangent table, unit radii, register codes.
// ----------------------------------------------------------------------------
package hvd_pkg;

  localparam int CordicStagesDef = 24;
  localparam int DataW           = 34;   // signed Q30 working word with headroom
  localparam int SqrtSteps       = 31;   // one root digit per step, 61-bit radicand
  localparam int SqrtTop         = 60;   // bit position of the first trial digit

  // register count outside the two CORDIC chains
  localparam int FixedLatency    = 11 + SqrtSteps;

  typedef logic signed [DataW-1:0] word_t;

  // configuration register indexes
  localparam logic [2:0] RegBaseLatitude  = 3'd0;
  localparam logic [2:0] RegBaseSouth     = 3'd1;
  localparam logic [2:0] RegBaseLongitude = 3'd2;
  localparam logic [2:0] RegBaseWest      = 3'd3;
  localparam logic [2:0] RegDistanceUnit  = 3'd4;

  typedef enum logic [1:0] {
    UnitFeet       = 2'd0,
    UnitMiles      = 2'd1,
    UnitMeters     = 2'd2,
    UnitKilometers = 2'd3
  } unit_e;

  localparam logic [32:0] Deg90Q24   = 33'd1509949440;
  localparam logic [32:0] Deg180Q24  = 33'd3019898880;
  localparam logic [63:0] PiQ60      = 64'h3243F6A8885A308D;
  // pi/180 in Q38, rounded
  localparam logic [63:0] RadK       = ((PiQ60 / 64'd180) + (64'd1 << 21)) >> 22;
  localparam logic [30:0] Q30One     = 31'h4000_0000;
  localparam logic [30:0] HalfPiQ30  = 31'h6487_ED51;
  localparam word_t       CordicGain = 34'sh026DD3B6A;
  localparam logic [33:0] DistMax    = '1;

  function automatic int latency(int stages);
    return FixedLatency + 2 * stages;
  endfunction

  function automatic logic [24:0] unit_radius(unit_e unit);
    logic [24:0] r;
    case (unit)
      UnitFeet:       r = 25'd20887680;   // 3956 mi * 5280
      UnitMiles:      r = 25'd3956;
      UnitMeters:     r = 25'd6367000;    // 6367 km * 1000
      UnitKilometers: r = 25'd6367;
      default:        r = 25'd3956;
    endcase
    return r;
  endfunction

  // atan(2^-i) in Q30
  function automatic word_t atan_q30(logic [4:0] i);
    word_t a;
    case (i)
      5'd0:  a = 34'sh03243F6A8;
      5'd1:  a = 34'sh01DAC6705;
      5'd2:  a = 34'sh00FADBAFC;
      5'd3:  a = 34'sh007F56EA6;
      5'd4:  a = 34'sh003FEAB76;
      5'd5:  a = 34'sh001FFD55B;
      5'd6:  a = 34'sh000FFFAAA;
      5'd7:  a = 34'sh0007FFF55;
      5'd8:  a = 34'sh0003FFFEA;
      5'd9:  a = 34'sh0001FFFFD;
      5'd10: a = 34'sh0000FFFFF;
      5'd11: a = 34'sh00007FFFF;
      5'd12: a = 34'sh00003FFFF;
      5'd13: a = 34'sh00001FFFF;
      5'd14: a = 34'sh00000FFFF;
      5'd15: a = 34'sh000007FFF;
      5'd16: a = 34'sh000003FFF;
      5'd17: a = 34'sh000001FFF;
      5'd18: a = 34'sh000000FFF;
      5'd19: a = 34'sh0000007FF;
      5'd20: a = 34'sh0000003FF;
      5'd21: a = 34'sh0000001FF;
      5'd22: a = 34'sh0000000FF;
      5'd23: a = 34'sh00000007F;
      5'd24: a = 34'sh00000003F;
      5'd25: a = 34'sh00000001F;
      5'd26: a = 34'sh00000000F;
      5'd27: a = 34'sh000000008;
      5'd28: a = 34'sh000000004;
      5'd29: a = 34'sh000000002;
      5'd30: a = 34'sh000000001;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### hw/rtl/hvd_cordic.sv
// ----------------------------------------------------------------------------
// hvd_cordic: fully pipelined CORDIC, one micro-rotation per register stage
// Rotation mode drives z to zero; vectoring mode drives y to zero.
// ----------------------------------------------------------------------------
module hvd_cordic #(
  parameter int STAGES    = hvd_pkg::CordicStagesDef,
  parameter bit VECTORING = 1'b0
) (
  input  logic          clk_i,
  input  hvd_pkg::word_t x_i,
  input  hvd_pkg::word_t y_i,
  input  hvd_pkg::word_t z_i,
  output hvd_pkg::word_t x_o,
  output hvd_pkg::word_t y_o,
  output hvd_pkg::word_t z_o
);

  hvd_pkg::word_t x_q [STAGES];
  hvd_pkg::word_t y_q [STAGES];
  hvd_pkg::word_t z_q [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    hvd_pkg::word_t xp, yp, zp, xs, ys, at;
    logic           up;

    if (i == 0) begin : g_first
      assign xp = x_i;
      assign yp = y_i;
      assign zp = z_i;
    end else begin : g_next
      assign xp = x_q[i-1];
      assign yp = y_q[i-1];
      assign zp = z_q[i-1];
    end

    assign xs = xp >>> i;
    assign ys = yp >>> i;
    assign at = hvd_pkg::atan_q30(5'(i));
    // up: rotate clockwise and add the table angle to z
    assign up = VECTORING ? ~yp[hvd_pkg::DataW-1] : zp[hvd_pkg::DataW-1];

    always_ff @(posedge clk_i) begin
      if (up) begin
        x_q[i] <= xp + ys;
        y_q[i] <= yp - xs;
        z_q[i] <= zp + at;
      end else begin
        x_q[i] <= xp - ys;
        y_q[i] <= yp + xs;
        z_q[i] <= zp - at;
      end
    end
  end

  assign x_o = x_q[STAGES-1];
  assign y_o = y_q[STAGES-1];
  assign z_o = z_q[STAGES-1];

endmodule

### hw/rtl/haversine_distance_top.sv
// ----------------------------------------------------------------------------
// haversine_distance_top: streaming great-circle distance from a base position
// Haversine formula over pipelined CORDIC sine/cosine, roots and atan2.
// ----------------------------------------------------------------------------
// The block takes one mobile position per clock and returns its distance from
// the configured base, one result per position, in order. The pipeline holds
// the two CORDIC chains (sine/cosine, then atan2), the 31-step square-root
// pipeline and eleven stages of conversion, products and scaling.
// busy never rises, so start may be held high every cycle. Results come as a
// one-cycle result_valid_o beat and cannot be held off: capture them when they
// show. Base position and unit are written through the cfg port (always
// ready); the user must write them only while no position is in flight, as the
// block itself does not enforce it. Writes to indexes above 4 do nothing.
// distance_o is unsigned with 8 fraction bits in the selected unit.
module haversine_distance_top #(
  parameter int CORDIC_STAGES = hvd_pkg::CordicStagesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // position beats
  input  logic        start,
  output logic        busy,
  input  logic [29:0] mobile_latitude_i,
  input  logic        mobile_south_i,
  input  logic [30:0] mobile_longitude_i,
  input  logic        mobile_west_i,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [30:0] cfg_data_i,
  // result beats
  output logic        result_valid_o,
  output logic [33:0] distance_o
);

  localparam int Latency = hvd_pkg::latency(CORDIC_STAGES);
  localparam int DW      = hvd_pkg::DataW;

  // product of two Q30 values, floor-shifted back to Q30
  function automatic hvd_pkg::word_t mul_q30(hvd_pkg::word_t a, hvd_pkg::word_t b);
    logic signed [2*DW-1:0] p;
    p = a * b;
    return hvd_pkg::word_t'(p >>> 30);
  endfunction

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  logic [29:0]    base_lat_q;
  logic           base_south_q;
  logic [30:0]    base_lon_q;
  logic           base_west_q;
  hvd_pkg::unit_e unit_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_lat_q   <= '0;
      base_south_q <= 1'b0;
      base_lon_q   <= '0;
      base_west_q  <= 1'b0;
      unit_q       <= hvd_pkg::UnitFeet;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        hvd_pkg::RegBaseLatitude:  base_lat_q   <= cfg_data_i[29:0];
        hvd_pkg::RegBaseSouth:     base_south_q <= cfg_data_i[0];
        hvd_pkg::RegBaseLongitude: base_lon_q   <= cfg_data_i;
        hvd_pkg::RegBaseWest:      base_west_q  <= cfg_data_i[0];
        hvd_pkg::RegDistanceUnit:  unit_q       <= hvd_pkg::unit_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Valid chain: one bit per pipeline register, no stalls
  // --------------------------------------------------------------------------
  logic               accept;
  logic [Latency-1:0] vld_q;

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Latency-2:0], accept};
    end
  end

  assign result_valid_o = vld_q[Latency-1];

  // --------------------------------------------------------------------------
  // Stage A: signed coordinates, differences (Q23 deg), doubled latitudes
  // --------------------------------------------------------------------------
  hvd_pkg::word_t lat1, lon1, lat2, lon2;
  hvd_pkg::word_t a_dlat_q, a_dlon_q;
  logic [30:0]    a_m1_q, a_m2_q;

  always_comb begin
    lat1 = {4'b0, base_lat_q};
    lon1 = {3'b0, base_lon_q};
    lat2 = {4'b0, mobile_latitude_i};
    lon2 = {3'b0, mobile_longitude_i};
    if (base_south_q)   lat1 = -lat1;
    if (base_west_q)    lon1 = -lon1;
    if (mobile_south_i) lat2 = -lat2;
    if (mobile_west_i)  lon2 = -lon2;
  end

  always_ff @(posedge clk_i) begin
    a_dlat_q <= lat2 - lat1;
    a_dlon_q <= lon2 - lon1;
    a_m1_q   <= {base_lat_q, 1'b0};
    a_m2_q   <= {mobile_latitude_i, 1'b0};
  end

  // --------------------------------------------------------------------------
  // Stage B: |diff| read as half angle in Q24 deg, reduced mod 180
  // Magnitudes stay below 360 deg, so one subtract is enough.
  // --------------------------------------------------------------------------
  logic [32:0] abs_lat, abs_lon;
  logic [32:0] b_hlat_q, b_hlon_q;
  logic [30:0] b_m1_q, b_m2_q;

  assign abs_lat = a_dlat_q[DW-1] ? 33'(-a_dlat_q) : 33'(a_dlat_q);
  assign abs_lon = a_dlon_q[DW-1] ? 33'(-a_dlon_q) : 33'(a_dlon_q);

  always_ff @(posedge clk_i) begin
    b_hlat_q <= (abs_lat >= hvd_pkg::Deg180Q24) ? abs_lat - hvd_pkg::Deg180Q24 : abs_lat;
    b_hlon_q <= (abs_lon >= hvd_pkg::Deg180Q24) ? abs_lon - hvd_pkg::Deg180Q24 : abs_lon;
    b_m1_q   <= a_m1_q;
    b_m2_q   <= a_m2_q;
  end

  // --------------------------------------------------------------------------
  // Stage C: fold every angle into [0, 90] deg
  // Sines only get squared, so sign is dropped; cosine above 90 deg is negated.
  // Order: 0 lat half diff, 1 lon half diff, 2 base lat, 3 mobile lat.
  // --------------------------------------------------------------------------
  logic [30:0] c_ang_q [4];
  logic [1:0]  c_neg_q;

  always_ff @(posedge clk_i) begin
    c_ang_q[0] <= (b_hlat_q > hvd_pkg::Deg90Q24) ? 31'(hvd_pkg::Deg180Q24 - b_hlat_q)
                                                 : 31'(b_hlat_q);
    c_ang_q[1] <= (b_hlon_q > hvd_pkg::Deg90Q24) ? 31'(hvd_pkg::Deg180Q24 - b_hlon_q)
                                                 : 31'(b_hlon_q);
    c_ang_q[2] <= ({2'b0, b_m1_q} > hvd_pkg::Deg90Q24)
                  ? 31'(hvd_pkg::Deg180Q24 - {2'b0, b_m1_q}) : b_m1_q;
    c_ang_q[3] <= ({2'b0, b_m2_q} > hvd_pkg::Deg90Q24)
                  ? 31'(hvd_pkg::Deg180Q24 - {2'b0, b_m2_q}) : b_m2_q;
    c_neg_q[0] <= {2'b0, b_m1_q} > hvd_pkg::Deg90Q24;
    c_neg_q[1] <= {2'b0, b_m2_q} > hvd_pkg::Deg90Q24;
  end

  // --------------------------------------------------------------------------
  // Stage D: degrees Q24 to radians Q30, rounded
  // --------------------------------------------------------------------------
  logic [31:0] d_rad_q [4];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      d_rad_q[k] <= 32'((64'(c_ang_q[k]) * hvd_pkg::RadK + 64'h8000_0000) >> 32);
    end
  end

  // cosine sign flags ride alongside the rotation CORDICs
  logic [1:0] neg_dly_q [CORDIC_STAGES+1];

  always_ff @(posedge clk_i) begin
    neg_dly_q[0] <= c_neg_q;
    for (int k = 1; k <= CORDIC_STAGES; k++) begin
      neg_dly_q[k] <= neg_dly_q[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // Rotation CORDICs: two sines, two cosines
  // --------------------------------------------------------------------------
  hvd_pkg::word_t sin_w [2];
  hvd_pkg::word_t cos_w [2];

  for (genvar k = 0; k < 2; k++) begin : g_sin
    hvd_cordic #(
      .STAGES   (CORDIC_STAGES),
      .VECTORING(1'b0)
    ) u_sin (
      .clk_i(clk_i),
      .x_i  (hvd_pkg::CordicGain),
      .y_i  ('0),
      .z_i  ({2'b0, d_rad_q[k]}),
      .x_o  (),
      .y_o  (sin_w[k]),
      .z_o  ()
    );
  end

  for (genvar k = 0; k < 2; k++) begin : g_cos
    hvd_cordic #(
      .STAGES   (CORDIC_STAGES),
      .VECTORING(1'b0)
    ) u_cos (
      .clk_i(clk_i),
      .x_i  (hvd_pkg::CordicGain),
      .y_i  ('0),
      .z_i  ({2'b0, d_rad_q[k+2]}),
      .x_o  (cos_w[k]),
      .y_o  (),
      .z_o  ()
    );
  end

  // --------------------------------------------------------------------------
  // Stages E-G: a = s1^2 + s2^2 * c1 * c2; E squares both sines, then one multiply per stage
  // --------------------------------------------------------------------------
  hvd_pkg::word_t e_p_q, e_q_q, e_c1_q, e_c2_q;
  hvd_pkg::word_t f_p_q, f_q_q, f_c2_q;
  hvd_pkg::word_t g_p_q, g_q_q;

  always_ff @(posedge clk_i) begin
    e_p_q  <= mul_q30(sin_w[1], sin_w[1]);
    e_q_q  <= mul_q30(sin_w[0], sin_w[0]);
    e_c1_q <= neg_dly_q[CORDIC_STAGES][0] ? -cos_w[0] : cos_w[0];
    e_c2_q <= neg_dly_q[CORDIC_STAGES][1] ? -cos_w[1] : cos_w[1];

    f_p_q  <= mul_q30(e_p_q, e_c1_q);
    f_q_q  <= e_q_q;
    f_c2_q <= e_c2_q;

    g_p_q  <= mul_q30(f_p_q, f_c2_q);
    g_q_q  <= f_q_q;
  end

  // --------------------------------------------------------------------------
  // Stage H: sum and clamp to [0, 1.0]
  // --------------------------------------------------------------------------
  logic signed [DW:0] hav_sum;
  logic [30:0]        h_a_q;

  assign hav_sum = {g_q_q[DW-1], g_q_q} + {g_p_q[DW-1], g_p_q};

  always_ff @(posedge clk_i) begin
    if (hav_sum[DW]) begin
      h_a_q <= '0;
    end else if (hav_sum > (DW+1)'(hvd_pkg::Q30One)) begin
      h_a_q <= hvd_pkg::Q30One;
    end else begin
      h_a_q <= 31'(hav_sum);
    end
  end

  // --------------------------------------------------------------------------
  // Square roots of a and 1-a (both in Q60), one result bit per stage
  // Root 0 gives sqrt(a), root 1 gives sqrt(1-a).
  // --------------------------------------------------------------------------
  logic [60:0] sq_v_q [2][hvd_pkg::SqrtSteps];
  logic [60:0] sq_r_q [2][hvd_pkg::SqrtSteps];
  logic [60:0] sq_init [2];

  assign sq_init[0] = {h_a_q, 30'b0};
  assign sq_init[1] = {31'(hvd_pkg::Q30One - h_a_q), 30'b0};

  for (genvar r = 0; r < 2; r++) begin : g_root
    for (genvar k = 0; k < hvd_pkg::SqrtSteps; k++) begin : g_step
      localparam logic [60:0] TrialBit = 61'(1) << (hvd_pkg::SqrtTop - 2 * k);
      logic [60:0] vp, rp;
      logic [61:0] trial;

      if (k == 0) begin : g_first
        assign vp = sq_init[r];
        assign rp = '0;
      end else begin : g_next
        assign vp = sq_v_q[r][k-1];
        assign rp = sq_r_q[r][k-1];
      end

      assign trial = {1'b0, rp} + {1'b0, TrialBit};

      always_ff @(posedge clk_i) begin
        if ({1'b0, vp} >= trial) begin
          sq_v_q[r][k] <= vp - trial[60:0];
          sq_r_q[r][k] <= (rp >> 1) + TrialBit;
        end else begin
          sq_v_q[r][k] <= vp;
          sq_r_q[r][k] <= rp >> 1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // atan2(sqrt(a), sqrt(1-a)) by vectoring CORDIC
  // --------------------------------------------------------------------------
  hvd_pkg::word_t vec_z;

  hvd_cordic #(
    .STAGES   (CORDIC_STAGES),
    .VECTORING(1'b1)
  ) u_atan (
    .clk_i(clk_i),
    .x_i  (DW'(sq_r_q[1][hvd_pkg::SqrtSteps-1])),
    .y_i  (DW'(sq_r_q[0][hvd_pkg::SqrtSteps-1])),
    .z_i  ('0),
    .x_o  (),
    .y_o  (),
    .z_o  (vec_z)
  );

  // --------------------------------------------------------------------------
  // Stages I-K: clamp angle to [0, pi/2], scale by radius, saturate
  // distance = (2*c * R + 2^21) >> 22 gives 8 fraction bits.
  // --------------------------------------------------------------------------
  logic [30:0] i_z_q;
  logic [34:0] j_dist_q;
  logic [33:0] distance_q;

  always_ff @(posedge clk_i) begin
    if (vec_z[DW-1]) begin
      i_z_q <= '0;
    end else if (vec_z > DW'(hvd_pkg::HalfPiQ30)) begin
      i_z_q <= hvd_pkg::HalfPiQ30;
    end else begin
      i_z_q <= vec_z[30:0];
    end

    j_dist_q <= 35'((57'({i_z_q, 1'b0}) * 57'(hvd_pkg::unit_radius(unit_q))
                     + (57'(1) << 21)) >> 22);

    distance_q <= j_dist_q[34] ? hvd_pkg::DistMax : j_dist_q[33:0];
  end

  assign distance_o = distance_q;

endmodule

### hw/rtl/hvd_checker.sv
// ----------------------------------------------------------------------------
// hvd_checker: port-level checks for haversine_distance_top
// Fixed latency in both directions and result range.
// ----------------------------------------------------------------------------
module hvd_checker #(
  parameter int CORDIC_STAGES = hvd_pkg::CordicStagesDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_valid_o,
  input logic [33:0] distance_o
);

  localparam int Latency = hvd_pkg::latency(CORDIC_STAGES);
  // just above pi times the largest radius (feet) in Q8
  localparam logic [33:0] DistBound = 34'h3_F000_0000;

  a_beat_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##Latency result_valid_o)
    else $error("accepted position gave no result at fixed latency");

  a_beat_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, Latency))
    else $error("result beat without a matching accepted position");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> distance_o <= DistBound)
    else $error("distance beyond half circumference");

endmodule

bind haversine_distance_top hvd_checker #(
  .CORDIC_STAGES(CORDIC_STAGES)
) u_hvd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .result_valid_o(result_valid_o),
  .distance_o    (distance_o)
);
